// ===== hdl/kic_pkg.sv =====
// ----------------------------------------------------------------------------
// kic_pkg: shared types and constants of the keypad integer calculator
// Key codes, operation and phase codes, and the structs that pass between
// the key entry, the arithmetic unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package kic_pkg;

    // Operand and result width
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int KEY_W  = 8;
    localparam int DIG_W  = 4;

    // Default digit limit per operand
    localparam int MAX_DIGITS_DEF = 7;

    // ASCII key codes
    localparam logic [KEY_W-1:0] KEY_ZERO   = 8'd48;
    localparam logic [KEY_W-1:0] KEY_NINE   = 8'd57;
    localparam logic [KEY_W-1:0] KEY_PLUS   = 8'd43;
    localparam logic [KEY_W-1:0] KEY_MINUS  = 8'd45;
    localparam logic [KEY_W-1:0] KEY_TIMES  = 8'd42;
    localparam logic [KEY_W-1:0] KEY_DIVIDE = 8'd47;
    localparam logic [KEY_W-1:0] KEY_EQUALS = 8'd61;
    localparam logic [KEY_W-1:0] KEY_CLEAR  = 8'd67;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_WAIT   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ALU_IDLE = 2'd0,
        ALU_RUN  = 2'd1,
        ALU_DONE = 2'd2
    } alu_state_t;

    // Request from key entry to the arithmetic unit
    typedef struct packed {
        logic              start;
        op_t               op;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } launch_t;

    // Status of the arithmetic unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] result;
        logic              div_zero;
    } alu_status_t;

endpackage

`default_nettype wire

// ===== hdl/kic_entry.sv =====
// ----------------------------------------------------------------------------
// kic_entry: key decode and operand entry
// Builds the two decimal operands digit by digit, latches the operator and
// launches the arithmetic unit on the equals key.
// ----------------------------------------------------------------------------
`default_nettype none

module kic_entry #(
    parameter int MAX_DIGITS = kic_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       key_valid,
    input  wire logic [kic_pkg::KEY_W-1:0]  key_code,
    output kic_pkg::launch_t                launch
);

    localparam logic [kic_pkg::DIG_W-1:0] MaxDig = kic_pkg::DIG_W'(MAX_DIGITS);

    kic_pkg::phase_t                phase_reg, phase_next;
    kic_pkg::op_t                   op_reg, op_next;
    logic [kic_pkg::DATA_W-1:0]     first_reg, first_next;
    logic [kic_pkg::DATA_W-1:0]     second_reg, second_next;
    logic [kic_pkg::DIG_W-1:0]      count_reg, count_next;

    logic                           is_digit;
    logic                           is_op;
    logic                           room;
    logic                           launch_start;
    logic [kic_pkg::DIG_W-1:0]      digit;
    logic [kic_pkg::DATA_W-1:0]     entry_acc;
    logic [kic_pkg::DATA_W-1:0]     entry_sum;

    // Key classification
    assign is_digit = (key_code >= kic_pkg::KEY_ZERO) && (key_code <= kic_pkg::KEY_NINE);
    assign is_op    = (key_code == kic_pkg::KEY_PLUS)  || (key_code == kic_pkg::KEY_MINUS) ||
                      (key_code == kic_pkg::KEY_TIMES) || (key_code == kic_pkg::KEY_DIVIDE);
    assign digit    = kic_pkg::DIG_W'(key_code - kic_pkg::KEY_ZERO);
    assign room     = count_reg < MaxDig;

    // acc*10 + digit as shifted terms
    assign entry_acc = (phase_reg == kic_pkg::PH_FIRST) ? first_reg : second_reg;
    assign entry_sum = {entry_acc[kic_pkg::DATA_W-4:0], 3'b000}
                     + {entry_acc[kic_pkg::DATA_W-2:0], 1'b0}
                     + kic_pkg::DATA_W'(digit);

    // Phase and operand update
    always_comb begin
        phase_next   = phase_reg;
        op_next      = op_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        count_next   = count_reg;
        launch_start = 1'b0;
        if (key_valid) begin
            unique case (phase_reg)
                kic_pkg::PH_FIRST: begin
                    if (is_digit) begin
                        if (room) begin
                            first_next = entry_sum;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (is_op) begin
                        priority if (key_code == kic_pkg::KEY_PLUS) begin
                            op_next = kic_pkg::OP_ADD;
                        end else if (key_code == kic_pkg::KEY_MINUS) begin
                            op_next = kic_pkg::OP_SUB;
                        end else if (key_code == kic_pkg::KEY_TIMES) begin
                            op_next = kic_pkg::OP_MUL;
                        end else begin
                            op_next = kic_pkg::OP_DIV;
                        end
                        count_next = '0;
                        phase_next = kic_pkg::PH_SECOND;
                    end
                end
                kic_pkg::PH_SECOND: begin
                    if (is_digit) begin
                        if (room) begin
                            second_next = entry_sum;
                            count_next  = count_reg + 1'b1;
                        end
                    end else if (key_code == kic_pkg::KEY_EQUALS) begin
                        launch_start = 1'b1;
                        phase_next   = kic_pkg::PH_WAIT;
                    end
                end
                default: begin
                    // waiting for clear
                    if (key_code == kic_pkg::KEY_CLEAR) begin
                        first_next  = '0;
                        second_next = '0;
                        count_next  = '0;
                        phase_next  = kic_pkg::PH_FIRST;
                    end
                end
            endcase
        end
    end

    assign launch.start  = launch_start;
    assign launch.op     = op_reg;
    assign launch.first  = first_reg;
    assign launch.second = second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= kic_pkg::PH_FIRST;
            op_reg     <= kic_pkg::OP_ADD;
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            op_reg     <= op_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kic_alu.sv =====
// ----------------------------------------------------------------------------
// kic_alu: arithmetic unit
// Add and subtract in one step; multiply by shift-and-add and divide by
// restoring division, one operand bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kic_alu (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire kic_pkg::launch_t launch,
    input  wire logic             take,
    output kic_pkg::alu_status_t  status
);

    localparam int W = kic_pkg::DATA_W;

    kic_pkg::alu_state_t        state_reg, state_next;
    kic_pkg::op_t               op_reg, op_next;
    logic [kic_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]               a_reg, a_next;     // multiplier / quotient
    logic [W-1:0]               b_reg, b_next;     // multiplicand / divisor
    logic [W-1:0]               acc_reg, acc_next; // product / remainder
    logic                       dz_reg, dz_next;

    logic [W:0]                 rem_sh;
    logic [W+1:0]               diff;
    logic                       fits;

    // Restoring division trial subtract
    assign rem_sh = {acc_reg, a_reg[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, b_reg};
    assign fits   = ~diff[W+1];

    // Sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        dz_next    = dz_reg;
        unique case (state_reg)
            kic_pkg::ALU_IDLE: begin
                if (launch.start) begin
                    op_next  = launch.op;
                    cnt_next = '1;
                    dz_next  = 1'b0;
                    unique case (launch.op)
                        kic_pkg::OP_ADD: begin
                            acc_next   = launch.first + launch.second;
                            state_next = kic_pkg::ALU_DONE;
                        end
                        kic_pkg::OP_SUB: begin
                            acc_next   = launch.first - launch.second;
                            state_next = kic_pkg::ALU_DONE;
                        end
                        kic_pkg::OP_MUL: begin
                            a_next     = launch.second;
                            b_next     = launch.first;
                            acc_next   = '0;
                            state_next = kic_pkg::ALU_RUN;
                        end
                        default: begin
                            a_next     = launch.first;
                            b_next     = launch.second;
                            acc_next   = '0;
                            dz_next    = (launch.second == '0);
                            state_next = kic_pkg::ALU_RUN;
                        end
                    endcase
                end
            end
            kic_pkg::ALU_RUN: begin
                if (op_reg == kic_pkg::OP_MUL) begin
                    if (a_reg[0]) begin
                        acc_next = acc_reg + b_reg;
                    end
                    b_next = {b_reg[W-2:0], 1'b0};
                    a_next = {1'b0, a_reg[W-1:1]};
                end else begin
                    // divisor zero yields an all-ones quotient by itself
                    acc_next = fits ? diff[W-1:0] : rem_sh[W-1:0];
                    a_next   = {a_reg[W-2:0], fits};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = kic_pkg::ALU_DONE;
                end
            end
            default: begin
                if (take) begin
                    state_next = kic_pkg::ALU_IDLE;
                end
            end
        endcase
    end

    assign status.busy     = (state_reg != kic_pkg::ALU_IDLE);
    assign status.done     = (state_reg == kic_pkg::ALU_DONE);
    assign status.result   = (op_reg == kic_pkg::OP_DIV) ? a_reg : acc_reg;
    assign status.div_zero = dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kic_pkg::ALU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        dz_reg  <= dz_next;
    end

endmodule

`default_nettype wire

// ===== hdl/keypad_integer_calculator.sv =====
// ----------------------------------------------------------------------------
// keypad_integer_calculator: four-function 32-bit keypad calculator
// One ASCII key per input beat; one result beat per completed calculation.
// ----------------------------------------------------------------------------
// Digit, operator and clear keys are taken one per cycle while the
// arithmetic unit is idle. The equals key starts that unit: add and
// subtract finish in a single step, multiply and divide run the 32
// one-bit steps of the shared shift-and-add / restoring-divide loop.
// While that unit is busy or holds a result the output register has not
// yet taken, s_tready is low. A finished result waits in the output
// register without blocking further keys.
`default_nettype none

module keypad_integer_calculator #(
    parameter int MAX_DIGITS = kic_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] result_value, [32] divide_by_zero
);

    kic_pkg::launch_t               launch;
    kic_pkg::alu_status_t           status;
    logic                           key_beat;
    logic                           take;

    logic                           out_valid_reg, out_valid_next;
    logic [kic_pkg::DATA_W-1:0]     out_result_reg;
    logic                           out_dz_reg;

    assign s_tready = ~status.busy;
    assign key_beat = s_tvalid & s_tready;

    kic_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_valid (key_beat),
        .key_code  (s_tdata),
        .launch    (launch)
    );

    kic_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .launch  (launch),
        .take    (take),
        .status  (status)
    );

    // Output register
    assign take = status.done & (~out_valid_reg | m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_result_reg <= status.result;
            out_dz_reg     <= status.div_zero;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_dz_reg, out_result_reg};

endmodule

`default_nettype wire
